@@ rtl/bol_pkg.sv @@
`default_nettype none

package bol_pkg;

  // List sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  // Item field widths
  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;

  // Width used to compare a position against the length
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_INS_FRONT  = 3'd0;
  localparam cmd_t CMD_INS_BACK   = 3'd1;
  localparam cmd_t CMD_INS_SECOND = 3'd2;
  localparam cmd_t CMD_READ_FWD   = 3'd3;
  localparam cmd_t CMD_READ_BWD   = 3'd4;
  localparam cmd_t CMD_DEL_POS    = 3'd5;
  localparam cmd_t CMD_DEL_VAL    = 3'd6;

  // Status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

endpackage

`default_nettype wire

@@ rtl/bounded_ordered_list_engine_core.sv @@
// Ordered list of signed 32-bit values in one 1-read/1-write RAM with a registered read.
// Each item sends its first result in the cycle after start at the earliest.
// Inserts and deletes move one entry at a time: a read, then a write back.
// A search reads, then compares, each entry visited; a readout reads, then sends, each element.
// busy stays high until the last result of an item is sent; results cannot be stalled.
// Synchronous reset empties the list (length to zero); RAM contents are left as they are.
`default_nettype none

module bounded_ordered_list_engine_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [bol_pkg::CMD_W-1:0] in_command,
  input  wire logic signed [bol_pkg::VAL_W-1:0] in_value,
  input  wire logic [bol_pkg::POS_W-1:0] in_position,
  output logic                           out_strobe,
  output logic signed [bol_pkg::VAL_W-1:0] out_element,
  output logic                           out_last,
  output logic [bol_pkg::STAT_W-1:0]     out_status
);
  import bol_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SHU_RD   = 4'd1;
  localparam logic [3:0] S_SHU_WR   = 4'd2;
  localparam logic [3:0] S_INS_WR   = 4'd3;
  localparam logic [3:0] S_OUT_RD   = 4'd4;
  localparam logic [3:0] S_OUT_EM   = 4'd5;
  localparam logic [3:0] S_SRCH_RD  = 4'd6;
  localparam logic [3:0] S_SRCH_CMP = 4'd7;
  localparam logic [3:0] S_REM_RD   = 4'd8;
  localparam logic [3:0] S_REM_WR   = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0] end_r, end_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;

  logic             ostb_r, ostb_nxt;
  logic [VAL_W-1:0] oel_r, oel_nxt;
  logic             olast_r, olast_nxt;
  status_t          ost_r, ost_nxt;

  // Entry store
  logic [VAL_W-1:0] mem [CAPACITY];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] rdata_r;

  // Helper sums on the cursor and length
  logic [LEN_W-1:0] cur_inc, cur_inc2, cur_dec, len_dec, rev_idx;
  logic [CMP_W-1:0] pos_ext, len_ext;
  logic             full, empty;

  assign cur_inc  = cur_r + LEN_W'(1);
  assign cur_inc2 = cur_r + LEN_W'(2);
  assign cur_dec  = cur_r - LEN_W'(1);
  assign len_dec  = len_r - LEN_W'(1);
  assign rev_idx  = len_dec - cur_r;
  assign pos_ext  = CMP_W'(in_position);
  assign len_ext  = CMP_W'(len_r);
  assign full     = (len_r == LEN_W'(CAPACITY));
  assign empty    = (len_r == '0);

  // Next-state and datapath control
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    ostb_nxt  = 1'b0;
    oel_nxt   = '0;
    olast_nxt = 1'b1;
    ost_nxt   = ST_OK;
    mem_we    = 1'b0;
    mem_waddr = cur_r[IDX_W-1:0];
    mem_wdata = rdata_r;
    mem_raddr = cur_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          val_nxt = in_value;
          case (in_command)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_SECOND: begin
              if (full) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_FULL;
              end else begin
                // insertion index
                if (in_command == CMD_INS_FRONT) begin
                  end_nxt = '0;
                end else if (in_command == CMD_INS_BACK || len_r < LEN_W'(2)) begin
                  end_nxt = len_r;
                end else begin
                  end_nxt = LEN_W'(1);
                end
                cur_nxt   = len_r;
                state_nxt = (end_nxt == len_r) ? S_INS_WR : S_SHU_RD;
              end
            end
            CMD_READ_FWD, CMD_READ_BWD: begin
              if (empty) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_EMPTY;
              end else begin
                cur_nxt   = '0;
                state_nxt = S_OUT_RD;
              end
            end
            CMD_DEL_POS: begin
              if (empty) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_EMPTY;
              end else if (pos_ext == '0 || pos_ext > len_ext) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_NOTFOUND;
              end else if (pos_ext == len_ext) begin
                // removing the back entry needs no moves
                len_nxt  = len_dec;
                ostb_nxt = 1'b1;
              end else begin
                cur_nxt   = LEN_W'(pos_ext - CMP_W'(1));
                state_nxt = S_REM_RD;
              end
            end
            CMD_DEL_VAL: begin
              if (empty) begin
                ostb_nxt = 1'b1;
                ost_nxt  = ST_EMPTY;
              end else begin
                cur_nxt   = '0;
                state_nxt = S_SRCH_RD;
              end
            end
            default: begin
              ostb_nxt = 1'b1;
              ost_nxt  = ST_NOTFOUND;
            end
          endcase
        end
      end

      // Open a gap: move entry cur-1 up to cur
      S_SHU_RD: begin
        mem_raddr = cur_dec[IDX_W-1:0];
        state_nxt = S_SHU_WR;
      end
      S_SHU_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        cur_nxt   = cur_dec;
        state_nxt = (cur_dec == end_r) ? S_INS_WR : S_SHU_RD;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = end_r[IDX_W-1:0];
        mem_wdata = val_r;
        len_nxt   = len_r + LEN_W'(1);
        ostb_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end

      // Readout, one element at a time: read, then emit
      S_OUT_RD: begin
        mem_raddr = (cmd_r == CMD_READ_FWD) ? cur_r[IDX_W-1:0] : rev_idx[IDX_W-1:0];
        state_nxt = S_OUT_EM;
      end
      S_OUT_EM: begin
        ostb_nxt  = 1'b1;
        oel_nxt   = rdata_r;
        olast_nxt = (cur_inc == len_r);
        cur_nxt   = cur_inc;
        state_nxt = (cur_inc == len_r) ? S_IDLE : S_OUT_RD;
      end

      // Linear search for the first match
      S_SRCH_RD: begin
        mem_raddr = cur_r[IDX_W-1:0];
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (rdata_r == val_r) begin
          if (cur_inc == len_r) begin
            len_nxt   = len_dec;
            ostb_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_REM_RD;
          end
        end else if (cur_inc == len_r) begin
          ostb_nxt  = 1'b1;
          ost_nxt   = ST_NOTFOUND;
          state_nxt = S_IDLE;
        end else begin
          cur_nxt   = cur_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      // Close the gap: move entry cur+1 down to cur
      S_REM_RD: begin
        mem_raddr = cur_inc[IDX_W-1:0];
        state_nxt = S_REM_WR;
      end
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[IDX_W-1:0];
        mem_wdata = rdata_r;
        cur_nxt   = cur_inc;
        if (cur_inc2 == len_r) begin
          len_nxt   = len_dec;
          ostb_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REM_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    oel_r   <= oel_nxt;
    olast_r <= olast_nxt;
    ost_r   <= ost_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_strobe  = ostb_r;
  assign out_element = oel_r;
  assign out_last    = olast_r;
  assign out_status  = ost_r;

endmodule

`default_nettype wire

@@ rtl/bol_chk.sv @@
`default_nettype none

module bol_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_strobe,
  input wire logic [bol_pkg::VAL_W-1:0]  out_element,
  input wire logic                       out_last,
  input wire logic [bol_pkg::STAT_W-1:0] out_status
);
  import bol_pkg::*;

  // An accepted item either goes to work or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || (out_strobe && out_last))
    else $error("accepted item neither started nor answered");

  // A readout in progress keeps the engine busy
  a_mid_readout_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final result while idle");

  // Engine goes idle only together with a final result
  a_idle_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe && out_last)
    else $error("busy dropped without a final result");

  // Status results are single, final and carry a zero element
  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_OK |-> out_last && out_element == '0)
    else $error("malformed status result");

endmodule

bind bounded_ordered_list_engine_core bol_chk u_bol_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_element(out_element),
  .out_last   (out_last),
  .out_status (out_status)
);

`default_nettype wire
